// ----- rtl/ggvc_pkg.sv -----
// ggvc_pkg: shared types, constants and the cordic arctangent table
// used by all modules of the go-to-goal velocity controller; no dependencies
package ggvc_pkg;

  localparam int CORDIC_ITERATIONS = 16;

  localparam int PosW  = 32;
  localparam int HeadW = 16;
  localparam int ErrW  = 33;
  // cordic datapath: magnitude grows to about 1.65 * sqrt(2) * 2^32
  localparam int CxW   = 36;
  localparam int ZW    = 20;
  localparam int LinW  = 31;
  localparam int AngW  = 32;

  localparam logic signed [ZW-1:0] PiQ16     = ZW'(205887);
  localparam logic signed [17:0]   PiQ13     = 18'sd25736;
  localparam logic signed [17:0]   TwoPiQ13  = 18'sd51472;
  localparam logic [15:0]          InvKQ16   = 16'd39797;
  localparam logic [LinW-1:0]      LinMax    = {LinW{1'b1}};

  localparam logic [1:0] RegPosMargin = 2'd0;
  localparam logic [1:0] RegAngMargin = 2'd1;
  localparam logic [1:0] RegLinGain   = 2'd2;
  localparam logic [1:0] RegAngGain   = 2'd3;

  typedef struct packed {
    logic [15:0] position_margin;
    logic [14:0] angle_margin;
    logic [15:0] linear_gain;
    logic [15:0] angular_gain;
  } cfg_t;

  typedef struct packed {
    logic signed [CxW-1:0] x;
    logic signed [CxW-1:0] y;
    logic signed [ZW-1:0]  z;
    logic signed [HeadW-1:0] heading;
    logic                  arrived;
  } cstage_t;

  function automatic logic signed [ZW-1:0] atan_lut(input int i);
    logic signed [ZW-1:0] t;
    begin
      unique case (i)
        0: t = ZW'(51472);
        1: t = ZW'(30386);
        2: t = ZW'(16055);
        3: t = ZW'(8150);
        4: t = ZW'(4091);
        5: t = ZW'(2047);
        6: t = ZW'(1024);
        7: t = ZW'(512);
        8: t = ZW'(256);
        9: t = ZW'(128);
        10: t = ZW'(64);
        11: t = ZW'(32);
        12: t = ZW'(16);
        13: t = ZW'(8);
        14: t = ZW'(4);
        15: t = ZW'(2);
        16: t = ZW'(1);
        default: t = '0;
      endcase
      return t;
    end
  endfunction

endpackage

// ----- rtl/ggvc_if.sv -----
// ggvc_if: valid/ready channels carrying pose requests and drive results
// depends on ggvc_pkg for field widths
interface ggvc_in_if;
  import ggvc_pkg::*;
  logic valid;
  logic ready;
  logic signed [PosW-1:0]  goal_x;
  logic signed [PosW-1:0]  goal_y;
  logic signed [PosW-1:0]  pose_x;
  logic signed [PosW-1:0]  pose_y;
  logic signed [HeadW-1:0] heading;
  modport source (output valid, goal_x, goal_y, pose_x, pose_y, heading, input ready);
  modport sink (input valid, goal_x, goal_y, pose_x, pose_y, heading, output ready);
endinterface

interface ggvc_out_if;
  import ggvc_pkg::*;
  logic valid;
  logic ready;
  logic [LinW-1:0]        linear_drive;
  logic signed [AngW-1:0] angular_drive;
  logic                   arrived;
  modport source (output valid, linear_drive, angular_drive, arrived, input ready);
  modport sink (input valid, linear_drive, angular_drive, arrived, output ready);
endinterface

// ----- rtl/ggvc_cordic.sv -----
// ggvc_cordic: pipelined vectoring cordic, one micro-rotation per stage
// depends on ggvc_pkg; stalls with a shared enable
module ggvc_cordic
  import ggvc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  logic    in_valid,
  input  cstage_t in_data,
  output logic    out_valid,
  output cstage_t out_data
);

  cstage_t stg_r [CORDIC_ITERATIONS+1];
  logic    vld_r [CORDIC_ITERATIONS+1];

  always_comb begin
    stg_r[0] = in_data;
    vld_r[0] = in_valid;
  end

  for (genvar i = 0; i < CORDIC_ITERATIONS; i++) begin : g_it
    cstage_t nxt;
    always_comb begin
      nxt = stg_r[i];
      if (stg_r[i].y > 0) begin
        nxt.x = stg_r[i].x + (stg_r[i].y >>> i);
        nxt.y = stg_r[i].y - (stg_r[i].x >>> i);
        nxt.z = stg_r[i].z + atan_lut(i);
      end else begin
        nxt.x = stg_r[i].x - (stg_r[i].y >>> i);
        nxt.y = stg_r[i].y + (stg_r[i].x >>> i);
        nxt.z = stg_r[i].z - atan_lut(i);
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1] <= vld_r[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        stg_r[i+1] <= nxt;
      end
    end
  end

  assign out_valid = vld_r[CORDIC_ITERATIONS];
  assign out_data  = stg_r[CORDIC_ITERATIONS];

endmodule

// ----- rtl/ggvc_law.sv -----
// ggvc_law: control law after the cordic; bearing, wrap, gains, saturation
// depends on ggvc_pkg; four register stages (last is the output) sharing one enable
module ggvc_law
  import ggvc_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  cfg_t            cfg,
  input  logic            in_valid,
  input  cstage_t         in_data,
  output logic            out_valid,
  output logic [LinW-1:0] lin_out,
  output logic signed [AngW-1:0] ang_out,
  output logic            arr_out
);

  // stage a: bearing, heading error, distance product
  logic signed [17:0] err_a_nxt, err_a_r;
  logic [51:0]        dprod_a_r;
  logic               arr_a_r, v_a_r;
  logic signed [ZW-1:0] zr;
  logic signed [17:0]   bear, e0;

  always_comb begin
    zr   = in_data.z + ZW'(4);
    bear = 18'(zr >>> 3);
    e0   = bear - 18'(in_data.heading);
    err_a_nxt = e0;
    if (e0 >= PiQ13) begin
      err_a_nxt = e0 - TwoPiQ13;
    end else if (e0 < -PiQ13) begin
      err_a_nxt = e0 + TwoPiQ13;
    end
  end

  // stages b and c: magnitudes, then gain products
  logic [16:0] aerr_b_r;
  logic        neg_b_r, arr_b_r, v_b_r;
  logic [35:0] dist_b_r;
  logic [32:0] turnp_c_r;
  logic [52:0] fwdp_c_r;
  logic        inm_c_r, neg_c_r, arr_c_r, v_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v_a_r <= in_valid;
      v_b_r <= v_a_r;
      v_c_r <= v_b_r;
      out_valid <= v_c_r;
    end
  end

  logic [17:0] aerr_w;
  logic [36:0] turn_w;
  logic [53:0] fwd_w;
  logic [LinW-1:0] lin_w;
  logic [32:0] tmag;

  always_comb begin
    aerr_w = err_a_r < 0 ? 18'(-err_a_r) : 18'(err_a_r);
    turn_w = 37'(turnp_c_r) + 37'd4096;
    tmag   = 33'(turn_w >> 13);
    if (tmag < 33'(cfg.angular_gain)) tmag = 33'(cfg.angular_gain);
    fwd_w  = 54'(fwdp_c_r) + 54'd32768;
    fwd_w  = fwd_w >> 16;
    if (fwd_w < 54'(cfg.linear_gain)) fwd_w = 54'(cfg.linear_gain);
    lin_w = (fwd_w > 54'(LinMax)) ? LinMax : LinW'(fwd_w);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      err_a_r   <= err_a_nxt;
      dprod_a_r <= 52'(in_data.x[CxW-1:0]) * 52'(InvKQ16);
      arr_a_r   <= in_data.arrived;
      aerr_b_r  <= aerr_w[16:0];
      neg_b_r   <= err_a_r < 0;
      dist_b_r  <= dprod_a_r[51:16];
      arr_b_r   <= arr_a_r;
      turnp_c_r <= 33'(cfg.angular_gain) * 33'(aerr_b_r);
      fwdp_c_r  <= 53'(cfg.linear_gain) * 53'(dist_b_r);
      inm_c_r   <= aerr_b_r < 17'(cfg.angle_margin);
      neg_c_r   <= neg_b_r;
      arr_c_r   <= arr_b_r;
      if (arr_c_r) begin
        lin_out <= '0;
        ang_out <= '0;
      end else begin
        lin_out <= inm_c_r ? lin_w : '0;
        ang_out <= neg_c_r ? -AngW'(tmag) : AngW'(tmag);
      end
      arr_out <= arr_c_r;
    end
  end

endmodule

// ----- rtl/go_to_goal_velocity_controller_top.sv -----
// go_to_goal_velocity_controller_top: top level, config registers, front end
// depends on ggvc_pkg, ggvc_if, ggvc_cordic and ggvc_law
//
// takes one request per cycle (goal and pose) unless stalled and returns
// linear and angular drive plus an arrived flag; results pass through one
// input stage, one cordic stage per iteration, three control-law stages and
// the output register; the whole pipeline advances together whenever the output
// register is empty or being taken, so a stall freezes every stage
module go_to_goal_velocity_controller_top
  import ggvc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  ggvc_in_if.sink     in_ch,
  ggvc_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  cfg_t cfg_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.position_margin <= 16'd3277;
      cfg_r.angle_margin    <= 15'd410;
      cfg_r.linear_gain     <= 16'd6554;
      cfg_r.angular_gain    <= 16'd6554;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegPosMargin: cfg_r.position_margin <= cfg_wdata;
        RegAngMargin: cfg_r.angle_margin    <= cfg_wdata[14:0];
        RegLinGain:   cfg_r.linear_gain     <= cfg_wdata;
        RegAngGain:   cfg_r.angular_gain    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline advances when output slot is free or being drained
  logic en;
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // front stage: errors, arrival test, quadrant pre-rotation
  logic signed [ErrW-1:0] dx, dy;
  logic [ErrW-1:0] adx, ady;
  cstage_t f_nxt, f_r;
  logic    f_v_r;

  always_comb begin
    dx  = ErrW'(in_ch.goal_x) - ErrW'(in_ch.pose_x);
    dy  = ErrW'(in_ch.goal_y) - ErrW'(in_ch.pose_y);
    adx = dx < 0 ? ErrW'(-dx) : ErrW'(dx);
    ady = dy < 0 ? ErrW'(-dy) : ErrW'(dy);
    f_nxt.heading = in_ch.heading;
    f_nxt.arrived = (adx < ErrW'(cfg_r.position_margin)) &&
                    (ady < ErrW'(cfg_r.position_margin));
    if (dx < 0) begin
      f_nxt.x = -CxW'(dx);
      f_nxt.y = -CxW'(dy);
      f_nxt.z = (dy >= 0) ? PiQ16 : -PiQ16;
    end else begin
      f_nxt.x = CxW'(dx);
      f_nxt.y = CxW'(dy);
      f_nxt.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (en) begin
      f_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_r <= f_nxt;
    end
  end

  logic    c_v;
  cstage_t c_d;

  ggvc_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(f_v_r), .in_data(f_r),
    .out_valid(c_v), .out_data(c_d)
  );

  ggvc_law u_law (
    .clk(clk), .rst_n(rst_n), .en(en), .cfg(cfg_r),
    .in_valid(c_v), .in_data(c_d),
    .out_valid(out_ch.valid), .lin_out(out_ch.linear_drive),
    .ang_out(out_ch.angular_drive), .arr_out(out_ch.arrived)
  );

  // an arrived result always carries zero drive
  a_arrived_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.arrived |-> out_ch.linear_drive == '0 &&
    out_ch.angular_drive == '0) else $error("arrived with nonzero drive");

  // a stalled result stays valid and keeps its angular drive
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid &&
    $stable(out_ch.angular_drive)) else $error("stalled result changed");

  // not arrived means turn drive is nonzero unless gain is zero
  a_turn_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.arrived && cfg_r.angular_gain != '0 &&
    $stable(cfg_r.angular_gain) |-> out_ch.angular_drive != '0)
    else $error("turn drive below gain");

endmodule

// ----- test/ggvc_tb_if.sv -----
`timescale 1ns / 1ps
// testbench result type shared by the scoreboard and the monitor
// depends on ggvc_pkg for field widths; the channels come from rtl/ggvc_if.sv
package ggvc_tb_types;
  import ggvc_pkg::*;

  typedef struct {
    logic [LinW-1:0]        linear_drive;
    logic signed [AngW-1:0] angular_drive;
    logic                   arrived;
  } drive_t;
endpackage

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// testbench for go_to_goal_velocity_controller_top: predicts drives per request
// depends on ggvc_pkg, ggvc_tb_types, ggvc_if and the rtl top level
module tb;
  import ggvc_pkg::*;
  import ggvc_tb_types::*;

  // predicted drives waiting for the pipeline, plus mismatch bookkeeping
  class drive_scoreboard;
    drive_t pending[$];
    int     errors;
    cfg_t   regs;

    function void note_request(logic signed [31:0] gx, logic signed [31:0] gy,
                               logic signed [31:0] px, logic signed [31:0] py,
                               logic signed [15:0] hd);
      longint dx, dy, x, y, z, xs, ys, brg, span, err, aerr, turn;
      longint unsigned fwd;
      drive_t d;
      dx = longint'(gx) - longint'(py * 0 + px);
      dy = longint'(gy) - longint'(py);
      d.linear_drive = '0;
      d.angular_drive = '0;
      d.arrived = 1'b0;
      if ((dx < 0 ? -dx : dx) < regs.position_margin &&
          (dy < 0 ? -dy : dy) < regs.position_margin) begin
        d.arrived = 1'b1;
        pending = {pending, d};
        return;
      end
      // vectoring rotation toward the x axis, angle in 2^-16 rad
      x = dx; y = dy; z = 0;
      if (x < 0) begin
        z = (y >= 0) ? 205887 : -205887;
        x = -x; y = -y;
      end
      for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys; y = y - xs; z = z + longint'(atan_step(i));
        end else begin
          x = x - ys; y = y + xs; z = z - longint'(atan_step(i));
        end
      end
      brg = (z + 4) >>> 3;
      span = longint'((unsigned'(x) * 39797) >> 16);
      err = brg - longint'(hd);
      while (err >= 25736) err -= 51472;
      while (err < -25736) err += 51472;
      aerr = err < 0 ? -err : err;
      turn = (longint'(regs.angular_gain) * aerr + 4096) >>> 13;
      if (turn < regs.angular_gain) turn = regs.angular_gain;
      if (err < 0) turn = -turn;
      if (aerr < regs.angle_margin) begin
        fwd = (64'(regs.linear_gain) * unsigned'(span) + 32768) >> 16;
        if (fwd < regs.linear_gain) fwd = regs.linear_gain;
        if (fwd > 64'h7FFF_FFFF) fwd = 64'h7FFF_FFFF;
        d.linear_drive = fwd[30:0];
      end
      d.angular_drive = turn[31:0];
      pending = {pending, d};
    endfunction

    // arctangent of 2^-i in 2^-16 rad, rounded
    function longint atan_step(int i);
      longint t[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                        256, 128, 64, 32, 16, 8, 4, 2, 1};
      return (i < 17) ? t[i] : 0;
    endfunction

    function void check_drive(drive_t got);
      drive_t want;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing pending");
        return;
      end
      want = pending.pop_front();
      if (got.linear_drive !== want.linear_drive)
        report_mismatch($sformatf("linear_drive got %0d want %0d",
                        got.linear_drive, want.linear_drive));
      if (got.angular_drive !== want.angular_drive)
        report_mismatch($sformatf("angular_drive got %0d want %0d",
                        got.angular_drive, want.angular_drive));
      if (got.arrived !== want.arrived)
        report_mismatch($sformatf("arrived got %0b want %0b", got.arrived, want.arrived));
    endfunction

    function void report_mismatch(string msg);
      errors++;
      if (errors <= 50) $display("mismatch: %s", msg);
    endfunction
  endclass

  localparam int Latency = CORDIC_ITERATIONS + 6;
  localparam int CycleLimit = 400000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [15:0] cfg_wdata;
  ggvc_in_if  req_ch();
  ggvc_out_if drv_ch();

  drive_scoreboard board;
  bit  calm;          // last part of the run: no idling at all
  bit  hold_long;     // receiver holds off for a long stretch
  int  cycles;

  go_to_goal_velocity_controller_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(req_ch), .out_ch(drv_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // inputs start known; the driving tasks take over after reset
  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = RegPosMargin;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.goal_x = '0;
    req_ch.goal_y = '0;
    req_ch.pose_x = '0;
    req_ch.pose_y = '0;
    req_ch.heading = '0;
    drv_ch.ready = 1'b0;
    board = new();
    board.regs.position_margin = 16'd3277;
    board.regs.angle_margin = 15'd410;
    board.regs.linear_gain = 16'd6554;
    board.regs.angular_gain = 16'd6554;
  end

  // note each accepted request and check each accepted result at the edge
  always @(posedge clk) begin
    drive_t got;
    if (rst_n) begin
      if (req_ch.valid && req_ch.ready)
        board.note_request(req_ch.goal_x, req_ch.goal_y, req_ch.pose_x,
                           req_ch.pose_y, req_ch.heading);
      if (drv_ch.valid && drv_ch.ready) begin
        got.linear_drive = drv_ch.linear_drive;
        got.angular_drive = drv_ch.angular_drive;
        got.arrived = drv_ch.arrived;
        board.check_drive(got);
      end
    end
  end

  // receiver: random stall bursts, one long hold-off, none at the end
  initial begin
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_long) begin
        drv_ch.ready <= 1'b0;
        repeat (3 * Latency) @(posedge clk);
        hold_long = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 6);
        drv_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        drv_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // run-time guard
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("timeout waiting for drives");
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      RegPosMargin: board.regs.position_margin = val;
      RegAngMargin: board.regs.angle_margin = val[14:0];
      RegLinGain:   board.regs.linear_gain = val;
      default:      board.regs.angular_gain = val;
    endcase
  endtask

  // one request, held until accepted; valid stays high into the next one unless a random gap drops it
  task automatic send_request(logic signed [31:0] gx, logic signed [31:0] gy,
                              logic signed [31:0] px, logic signed [31:0] py,
                              logic signed [15:0] hd);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.goal_x <= gx;
    req_ch.goal_y <= gy;
    req_ch.pose_x <= px;
    req_ch.pose_y <= py;
    req_ch.heading <= hd;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // drain: drop valid, wait until every prediction is matched, then idle
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  // random request, often with the pose near the goal so arrival and small errors occur often
  task automatic random_request(int spread);
    logic signed [31:0] gx, gy, px, py;
    logic signed [15:0] hd;
    gx = $urandom;
    gy = $urandom;
    case ($urandom_range(0, 3))
      0: begin px = gx + $signed($urandom_range(0, 2 * spread)) - spread;
               py = gy + $signed($urandom_range(0, 2 * spread)) - spread; end
      1: begin px = gx - ($signed($urandom) >>> $urandom_range(8, 20));
               py = gy - ($signed($urandom) >>> $urandom_range(8, 20)); end
      2: begin px = $urandom >> 1; py = -($urandom >> 1); gx = -px; gy = -py; end
      default: begin px = $urandom; py = $urandom; end
    endcase
    hd = ($urandom_range(0, 7) == 0) ? 16'($urandom) :
         16'($signed($urandom_range(0, 51472)) - 25736);
    send_request(gx, gy, px, py, hd);
  endtask

  initial begin
    logic signed [31:0] big;
    calm = 1'b0;
    hold_long = 1'b0;
    big = 32'sh7FFF_FFFF;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: default registers
    send_request(0, 0, 0, 0, 0);                         // arrived at origin
    send_request(3276, -3276, 0, 0, 0);                  // just inside margin
    send_request(3277, 0, 0, 0, 0);                      // on the margin edge
    send_request(big, big, -big - 1, -big - 1, 0);       // largest errors
    send_request(-big - 1, -big - 1, big, big, 16'sh7FFF);
    send_request(-big - 1, 0, big, 0, -16'sh8000);       // goal behind, y zero
    send_request(-65536, -1, 0, 0, 25736);               // bearing near -pi
    send_request(65536, 0, 0, 0, 0);                     // zero heading error
    send_request(0, 65536, 0, 0, 12868);                 // facing the goal
    send_request(0, -65536, 0, 0, 12868);                // turn the other way
    send_request(-65536, 65536, 0, 0, -25736);
    drain();

    // directed: zero margins and extreme gains
    write_reg(RegPosMargin, 16'd0);
    write_reg(RegAngMargin, 16'd25736);
    write_reg(RegLinGain, 16'hFFFF);
    write_reg(RegAngGain, 16'hFFFF);
    send_request(0, 0, 0, 0, 0);                         // zero error, not arrived
    send_request(big, big, -big - 1, -big - 1, 0);       // forward drive saturates
    send_request(1, 0, 0, 0, -25736);
    send_request(0, 0, 0, 0, 25736);
    drain();
    write_reg(RegLinGain, 16'd0);
    write_reg(RegAngGain, 16'd0);
    write_reg(RegAngMargin, 16'h7FFF);
    send_request(65536, 65536, 0, 0, 100);
    send_request(0, 0, 0, 0, -100);
    drain();

    // random phases under several register settings
    for (int phase = 0; phase < 4; phase++) begin
      write_reg(RegPosMargin, phase == 3 ? 16'hFFFF : 16'($urandom));
      write_reg(RegAngMargin, phase == 0 ? 16'd410 : 16'($urandom_range(0, 25736)));
      write_reg(RegLinGain, 16'($urandom));
      write_reg(RegAngGain, phase == 1 ? 16'd6554 : 16'($urandom));
      for (int n = 0; n < 100; n++) begin
        if (phase == 1 && n == 20) hold_long = 1'b1;
        if (phase == 3 && n == 60) calm = 1'b1;
        random_request(phase == 3 ? 70000 : 8000);
      end
      drain();
    end

    if (board.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
